FILE: rtl/est_pkg.sv
package est_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int MAX_IDENT    = 255;
   localparam int EVENT_KINDS  = 64;
   localparam int RESULT_LIMIT = 16;

   localparam int OP_W      = 2;
   localparam int EVENT_W   = 6;
   localparam int HANDLER_W = 16;
   localparam int ID_W      = 8;
   localparam int ARG_W     = 32;
   localparam int KIND_W    = 2;

   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int USE_W       = $clog2(SLOT_COUNT + 1);
   localparam int IDENT_CNT_W = $clog2(MAX_IDENT + 1);
   localparam int FIRE_CNT_W  = $clog2(RESULT_LIMIT + 1);
   localparam int EV_CMP_W    = ($clog2(EVENT_KINDS + 1) > EVENT_W) ?
                                $clog2(EVENT_KINDS + 1) : EVENT_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_FIRE    = 2'd2,
      KIND_NOTHING = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 taken;
      logic [EVENT_W-1:0]   event_code;
      logic [HANDLER_W-1:0] handler;
      logic [ID_W-1:0]      ident;
   } slot_type;

endpackage

FILE: rtl/est_if.sv
interface est_req_if;
   import est_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [EVENT_W-1:0]   event_code;
   logic [HANDLER_W-1:0] handler_ref;
   logic [ID_W-1:0]      listener_id;
   logic [ARG_W-1:0]     event_arg;

   modport source (output valid, operation, event_code, handler_ref, listener_id, event_arg,
                   input ready);
   modport sink (input valid, operation, event_code, handler_ref, listener_id, event_arg,
                 output ready);
endinterface

interface est_rsp_if;
   import est_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    result_kind;
   logic                 success;
   logic [ID_W-1:0]      assigned_id;
   logic [HANDLER_W-1:0] fire_handler;
   logic [ARG_W-1:0]     fire_arg;
   logic                 last;

   modport source (output valid, result_kind, success, assigned_id, fire_handler, fire_arg,
                   last, input ready);
   modport sink (input valid, result_kind, success, assigned_id, fire_handler, fire_arg,
                 last, output ready);
endinterface

FILE: rtl/event_subscription_table.sv
// Event subscription table: a fixed set of subscription slots kept in a ring of cells.
// req channel: one operation per transfer (add, remove by id, dispatch); operation 3
// is taken and dropped without any response.
// rsp channel: add and remove give one response each; a dispatch gives one fire per
// matching handler in slot order (at most 16), or one "matched nothing" response.
// The last flag marks the final response of each request.
// Each accepted request rotates the ring once, one slot past the controller per cycle
// while the scan is not stalled, then posts the final response and returns to idle.
// The response of an add or remove is registered in the done state after the rotation.
// The rotation of the ring sets the rate: one request at a time.
// A stalled rsp holds its output register; a dispatch keeps scanning until a second
// fire finds the output register still full, then the ring pauses.
// Reset (synchronous) frees every slot, closes all slots and sets the next id to one;
// slot contents are only read once written.
module event_subscription_table (
   input logic         clock,
   input logic         reset,
   est_req_if.sink     req,
   est_rsp_if.source   rsp
);
   import est_pkg::*;

   slot_type                chain [SLOT_COUNT];
   slot_type                write_back;
   logic                    shift;
   logic [SLOT_COUNT-1:0]   taken_vec;

   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      est_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .slot_in  ((k == 0) ? write_back : chain[(k == 0) ? 0 : k - 1]),
         .slot_out (chain[k])
      );
      assign taken_vec[k] = chain[k].taken;
   end

   est_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .head       (chain[SLOT_COUNT-1]),
      .write_back (write_back),
      .shift      (shift)
   );

   // the ring never turns while a new request can be taken
   a_idle_no_shift : assert property (@(posedge clock) disable iff (reset)
      !(req.ready && shift))
      else $error("ring rotating while idle");

   // a single pass changes at most one slot's taken bit per cycle
   a_taken_step : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(taken_vec) <= $countones($past(taken_vec)) + 1))
      else $error("more than one slot taken in one cycle");

   a_clean_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.result_kind != KIND_FIRE)) |->
      ((rsp.fire_handler == '0) && (rsp.fire_arg == '0)))
      else $error("handler or argument on a non-fire response");

   a_fire_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.result_kind == KIND_FIRE)) |->
      (rsp.success && (rsp.fire_handler != '0)))
      else $error("bad handler fire");

endmodule

FILE: rtl/est_cell.sv
module est_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  est_pkg::slot_type slot_in,
   output est_pkg::slot_type slot_out
);
   import est_pkg::*;

   logic                 taken_ff;
   logic [EVENT_W-1:0]   event_ff;
   logic [HANDLER_W-1:0] handler_ff;
   logic [ID_W-1:0]      ident_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 1'b0;
      end else if (shift) begin
         taken_ff <= slot_in.taken;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         event_ff   <= slot_in.event_code;
         handler_ff <= slot_in.handler;
         ident_ff   <= slot_in.ident;
      end
   end

   assign slot_out.taken      = taken_ff;
   assign slot_out.event_code = event_ff;
   assign slot_out.handler    = handler_ff;
   assign slot_out.ident      = ident_ff;

endmodule

FILE: rtl/est_ctrl.sv
module est_ctrl (
   input  logic              clock,
   input  logic              reset,
   est_req_if.sink           req,
   est_rsp_if.source         rsp,
   input  est_pkg::slot_type head,
   output est_pkg::slot_type write_back,
   output logic              shift
);
   import est_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   op_type                  op_ff, op_in;
   logic [EVENT_W-1:0]      ev_ff, ev_in;
   logic [HANDLER_W-1:0]    handler_ff, handler_in;
   logic [ID_W-1:0]         rid_ff, rid_in;
   logic [ARG_W-1:0]        arg_ff, arg_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic                    done_ff, done_in;
   logic [USE_W-1:0]        in_use_ff, in_use_in;
   logic [IDENT_CNT_W-1:0]  next_id_ff, next_id_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [HANDLER_W-1:0]    pend_handler_ff, pend_handler_in;
   logic [FIRE_CNT_W-1:0]   fire_cnt_ff, fire_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic                    success_ff, success_in;
   logic [ID_W-1:0]         out_id_ff, out_id_in;
   logic [HANDLER_W-1:0]    out_handler_ff, out_handler_in;
   logic [ARG_W-1:0]        out_arg_ff, out_arg_in;
   logic                    last_ff, last_in;

   logic                    out_free;
   logic [USE_W-1:0]        idx_ext;
   logic                    opened;
   logic                    ev_ok;
   logic                    hit_add;
   logic                    hit_rm;
   logic                    match;
   logic                    stall;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign idx_ext  = USE_W'(idx_ff);
   assign opened   = idx_ext < in_use_ff;
   assign ev_ok    = EV_CMP_W'(ev_ff) < EV_CMP_W'(EVENT_KINDS);

   // first free opened slot, else the next unopened one as it comes round
   assign hit_add = (op_ff == OP_ADD) && !done_ff && ev_ok &&
                    ((opened && !head.taken) || (idx_ext == in_use_ff));
   assign hit_rm  = (op_ff == OP_REMOVE) && !done_ff && (rid_ff != '0) && opened &&
                    head.taken && (head.ident == rid_ff);
   assign match   = (op_ff == OP_DISPATCH) && ev_ok && head.taken &&
                    (head.event_code == ev_ff) && (head.handler != '0) &&
                    (fire_cnt_ff < FIRE_CNT_W'(RESULT_LIMIT));
   // one fire is held back so that last can be set on the final one
   assign stall   = match && pend_valid_ff && !out_free;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      op_in           = op_ff;
      ev_in           = ev_ff;
      handler_in      = handler_ff;
      rid_in          = rid_ff;
      arg_in          = arg_ff;
      id_in           = id_ff;
      done_in         = done_ff;
      in_use_in       = in_use_ff;
      next_id_in      = next_id_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      fire_cnt_in     = fire_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      kind_in         = kind_ff;
      success_in      = success_ff;
      out_id_in       = out_id_ff;
      out_handler_in  = out_handler_ff;
      out_arg_in      = out_arg_ff;
      last_in         = last_ff;
      write_back      = head;
      shift           = 1'b0;
      req.ready       = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && (req.operation != OP_NONE)) begin
               op_in         = op_type'(req.operation);
               ev_in         = req.event_code;
               handler_in    = req.handler_ref;
               rid_in        = req.listener_id;
               arg_in        = req.event_arg;
               idx_in        = '0;
               done_in       = 1'b0;
               pend_valid_in = 1'b0;
               fire_cnt_in   = '0;
               if (req.operation == OP_ADD) begin
                  id_in      = ID_W'(next_id_ff);
                  next_id_in = (next_id_ff >= IDENT_CNT_W'(MAX_IDENT)) ?
                               IDENT_CNT_W'(1) : next_id_ff + IDENT_CNT_W'(1);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               shift = 1'b1;
               if (hit_add) begin
                  write_back.taken      = 1'b1;
                  write_back.event_code = ev_ff;
                  write_back.handler    = handler_ff;
                  write_back.ident      = id_ff;
                  done_in               = 1'b1;
                  if (idx_ext == in_use_ff) begin
                     in_use_in = in_use_ff + USE_W'(1);
                  end
               end
               if (hit_rm) begin
                  write_back.taken = 1'b0;
                  done_in          = 1'b1;
               end
               if (match) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     kind_in        = KIND_FIRE;
                     success_in     = 1'b1;
                     out_id_in      = '0;
                     out_handler_in = pend_handler_ff;
                     out_arg_in     = arg_ff;
                     last_in        = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_handler_in = head.handler;
                  fire_cnt_in     = fire_cnt_ff + FIRE_CNT_W'(1);
               end
               idx_in = idx_ff + SLOT_W'(1);
               if (idx_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               last_in        = 1'b1;
               out_id_in      = '0;
               out_handler_in = '0;
               out_arg_in     = '0;
               success_in     = done_ff;
               case (op_ff)
                  OP_ADD: begin
                     kind_in   = KIND_ADD;
                     out_id_in = done_ff ? id_ff : '0;
                  end
                  OP_REMOVE: begin
                     kind_in = KIND_REMOVE;
                  end
                  default: begin
                     if (pend_valid_ff) begin
                        kind_in        = KIND_FIRE;
                        success_in     = 1'b1;
                        out_handler_in = pend_handler_ff;
                        out_arg_in     = arg_ff;
                     end else begin
                        kind_in    = KIND_NOTHING;
                        success_in = 1'b0;
                     end
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_use_ff     <= '0;
         next_id_ff    <= IDENT_CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
         idx_ff        <= '0;
         fire_cnt_ff   <= '0;
         op_ff         <= OP_NONE;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         next_id_ff    <= next_id_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         done_ff       <= done_in;
         idx_ff        <= idx_in;
         fire_cnt_ff   <= fire_cnt_in;
         op_ff         <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff           <= ev_in;
      handler_ff      <= handler_in;
      rid_ff          <= rid_in;
      arg_ff          <= arg_in;
      id_ff           <= id_in;
      pend_handler_ff <= pend_handler_in;
      kind_ff         <= kind_in;
      success_ff      <= success_in;
      out_id_ff       <= out_id_in;
      out_handler_ff  <= out_handler_in;
      out_arg_ff      <= out_arg_in;
      last_ff         <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = kind_ff;
   assign rsp.success      = success_ff;
   assign rsp.assigned_id  = out_id_ff;
   assign rsp.fire_handler = out_handler_ff;
   assign rsp.fire_arg     = out_arg_ff;
   assign rsp.last         = last_ff;

endmodule
